>>> rtl/rtwg_pkg.sv
package rtwg_pkg;

   localparam int MAX_TAPS    = 64;
   localparam int MAX_WIDTH   = 4096;
   localparam int GAUSS_DEPTH = 256;

   localparam int CSR_W       = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int IDX_W       = 12;
   localparam int WEIGHT_W    = 16;
   localparam int SUM_W       = 24;

   localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
   localparam int CNT_W       = $clog2(MAX_TAPS + 1);
   localparam int RAM_DEPTH   = 2 * MAX_TAPS;
   localparam int RAM_AW      = $clog2(RAM_DEPTH);

   localparam int GAUSS_IDX_W = $clog2(GAUSS_DEPTH);
   localparam int GAUSS_SHIFT = GAUSS_IDX_W - 2;

   localparam int POS_W       = 2 * CSR_W + 1;

   localparam int DIV_NUM_W       = 32;
   localparam int DIV_DEN_W       = SUM_W;
   localparam int DIV_Q_W         = 17;
   localparam int DIV_STEP_W      = 5;
   localparam int DIV_LONG_STEPS  = DIV_Q_W;
   localparam int DIV_SHORT_STEPS = GAUSS_IDX_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WEIGHT_W-1:0] ONE_Q15 = WEIGHT_W'(32768);
   localparam logic [CSR_W-1:0]    MAX_WIDTH_V = CSR_W'(MAX_WIDTH);

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE  = 2'd2;

   localparam longint EXP_M1_Q30     = 395007542;
   localparam longint GAUSS_DEPTH_SQ = longint'(GAUSS_DEPTH) * longint'(GAUSS_DEPTH);
   localparam longint SERIES_DIV [16] = '{1, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15};

   typedef logic [CSR_W-1:0] width_type;
   typedef logic [WEIGHT_W-1:0] gauss_table_type [GAUSS_DEPTH];

   typedef struct packed {
      logic [IDX_W-1:0] target;
      logic [CNT_W-1:0] count;
      logic [SUM_W-1:0] sum;
      logic             cut;
      logic             bank;
   } run_desc_type;

   typedef struct packed {
      logic                en;
      logic [RAM_AW-1:0]   addr;
      logic [WEIGHT_W-1:0] weight;
      logic [IDX_W-1:0]    source;
   } tap_write_type;

   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
   } tap_read_type;

   function automatic logic [WEIGHT_W-1:0] gauss_entry(input int unsigned idx);
      longint unsigned odd_v;
      longint unsigned x;
      longint unsigned n;
      longint unsigned r;
      longint          f;
      longint          term;
      longint          acc;
      odd_v = 2 * longint'(idx) + 1;
      x     = (2 * odd_v * odd_v) << 16;
      x     = (x + GAUSS_DEPTH_SQ / 2) / GAUSS_DEPTH_SQ;
      n     = x >> 16;
      f     = longint'(x & 64'hFFFF);
      term  = longint'(1) << 30;
      acc   = term;
      for (int k = 1; k <= 15; k++) begin
         term = (term * f) >>> 16;
         term = term / SERIES_DIV[k];
         acc  = (k % 2 == 1) ? acc - term : acc + term;
      end
      if (acc < 0) begin
         acc = 0;
      end
      while (n > 0) begin
         acc = (acc * EXP_M1_Q30 + (longint'(1) << 29)) >>> 30;
         n   = n - 1;
      end
      r = ($unsigned(acc) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
         r = 64'd32768;
      end
      return r[WEIGHT_W-1:0];
   endfunction

   function automatic gauss_table_type build_gauss_table();
      gauss_table_type tbl;
      for (int i = 0; i < GAUSS_DEPTH; i++) begin
         tbl[i] = gauss_entry(i);
      end
      return tbl;
   endfunction

   localparam gauss_table_type GAUSS_TABLE = build_gauss_table();

endpackage

>>> rtl/resample_tap_weight_generator_unit.sv
// Front: setup, then an in-order scan of source pixels; a kept tap goes to a take state
// (gaussian: after the 8-step index divider). The scan stops past the window. Back: each
// emitted tap is read from its buffer and put through the 17-step normalizing divider.
// Two runs may be in flight (double-banked tap buffers); throughput is the slower side.
// Reset is synchronous: source and target width return to 1, filter to box,
// queue and both sides to idle. Tap buffers are not cleared.
module resample_tap_weight_generator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rtwg_pkg::IDX_W-1:0]    req_target_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rtwg_pkg::IDX_W-1:0]    rsp_target_echo,
   output logic [rtwg_pkg::IDX_W-1:0]    rsp_source_index,
   output logic [rtwg_pkg::WEIGHT_W-1:0] rsp_tap_weight,
   output logic                          rsp_last_tap,
   output logic                          rsp_no_taps,
   output logic                          rsp_overflow,
   input  logic                          csr_write_enable,
   input  logic [rtwg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtwg_pkg::CSR_W-1:0]    csr_write_data
);
   import rtwg_pkg::*;

   width_type     source_width_ff, source_width_in;
   width_type     target_width_ff, target_width_in;
   logic          filter_mode_ff, filter_mode_in;
   width_type     src_clamped;
   width_type     tgt_clamped;

   tap_write_type tap_wr;
   tap_read_type  tap_rd;
   run_desc_type  push_desc;
   run_desc_type  pop_desc;
   logic          push_valid;
   logic          push_ready;
   logic          pop_valid;
   logic          pop_ready;
   logic          run_done;
   logic [WEIGHT_W-1:0] weight_rd;
   logic [IDX_W-1:0]    source_rd;

   always_comb begin
      source_width_in = source_width_ff;
      target_width_in = target_width_ff;
      filter_mode_in  = filter_mode_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SOURCE_WIDTH: source_width_in = csr_write_data;
            CSR_TARGET_WIDTH: target_width_in = csr_write_data;
            CSR_FILTER_MODE:  filter_mode_in  = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_width_ff <= CSR_W'(1);
         target_width_ff <= CSR_W'(1);
         filter_mode_ff  <= 1'b0;
      end else begin
         source_width_ff <= source_width_in;
         target_width_ff <= target_width_in;
         filter_mode_ff  <= filter_mode_in;
      end
   end

   assign src_clamped = (source_width_ff > MAX_WIDTH_V) ? MAX_WIDTH_V : source_width_ff;
   assign tgt_clamped = (target_width_ff > MAX_WIDTH_V) ? MAX_WIDTH_V : target_width_ff;

   rtwg_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_index (req_target_index),
      .src_width        (src_clamped),
      .tgt_width        (tgt_clamped),
      .gauss_mode       (filter_mode_ff),
      .run_done         (run_done),
      .tap_wr           (tap_wr),
      .desc             (push_desc),
      .desc_valid       (push_valid),
      .desc_ready       (push_ready)
   );

   rtwg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_desc)
   );

   rtwg_ram #(.WIDTH(WEIGHT_W), .DEPTH(RAM_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (tap_wr.en),
      .wr_addr (tap_wr.addr),
      .wr_data (tap_wr.weight),
      .rd_en   (tap_rd.en),
      .rd_addr (tap_rd.addr),
      .rd_data (weight_rd)
   );

   rtwg_ram #(.WIDTH(IDX_W), .DEPTH(RAM_DEPTH)) u_source_ram (
      .clock   (clock),
      .wr_en   (tap_wr.en),
      .wr_addr (tap_wr.addr),
      .wr_data (tap_wr.source),
      .rd_en   (tap_rd.en),
      .rd_addr (tap_rd.addr),
      .rd_data (source_rd)
   );

   rtwg_norm u_norm (
      .clock            (clock),
      .reset            (reset),
      .desc             (pop_desc),
      .desc_valid       (pop_valid),
      .desc_ready       (pop_ready),
      .tap_rd           (tap_rd),
      .weight_rd        (weight_rd),
      .source_rd        (source_rd),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_target_echo  (rsp_target_echo),
      .rsp_source_index (rsp_source_index),
      .rsp_tap_weight   (rsp_tap_weight),
      .rsp_last_tap     (rsp_last_tap),
      .rsp_no_taps      (rsp_no_taps),
      .rsp_overflow     (rsp_overflow),
      .run_done         (run_done)
   );

endmodule

>>> rtl/rtwg_ram.sv
module rtwg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/rtwg_div.sv
module rtwg_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           long_op,
   input  logic [rtwg_pkg::DIV_NUM_W-1:0] num,
   input  logic [rtwg_pkg::DIV_DEN_W-1:0] den,
   output logic                           done,
   output logic [rtwg_pkg::DIV_Q_W-1:0]   quot
);
   import rtwg_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] steps_ff, steps_in;
   logic [DIV_DEN_W-1:0]  rem_ff, rem_in;
   logic [DIV_DEN_W-1:0]  den_ff, den_in;
   logic [DIV_Q_W-1:0]    low_ff, low_in;
   logic [DIV_Q_W-1:0]    quot_ff, quot_in;
   logic [DIV_DEN_W:0]    trial;
   logic                  fits;

   assign trial = {rem_ff, low_ff[DIV_Q_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         den_in  = den;
         quot_in = '0;
         if (long_op) begin
            steps_in = DIV_STEP_W'(DIV_LONG_STEPS);
            rem_in   = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_LONG_STEPS]);
            low_in   = num[DIV_LONG_STEPS-1:0];
         end else begin
            steps_in = DIV_STEP_W'(DIV_SHORT_STEPS);
            rem_in   = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_SHORT_STEPS]);
            low_in   = {num[DIV_SHORT_STEPS-1:0], {(DIV_Q_W - DIV_SHORT_STEPS){1'b0}}};
         end
      end else if (busy_ff) begin
         rem_in   = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         low_in   = {low_ff[DIV_Q_W-2:0], 1'b0};
         quot_in  = {quot_ff[DIV_Q_W-2:0], fits};
         steps_in = steps_ff - 1'b1;
         if (steps_ff == DIV_STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      steps_ff <= steps_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      low_ff   <= low_in;
      quot_ff  <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/rtwg_scan.sv
module rtwg_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rtwg_pkg::IDX_W-1:0]    req_target_index,
   input  rtwg_pkg::width_type           src_width,
   input  rtwg_pkg::width_type           tgt_width,
   input  logic                          gauss_mode,
   input  logic                          run_done,
   output rtwg_pkg::tap_write_type       tap_wr,
   output rtwg_pkg::run_desc_type        desc,
   output logic                          desc_valid,
   input  logic                          desc_ready
);
   import rtwg_pkg::*;

   typedef enum logic [5:0] {
      SC_IDLE   = 6'b000001,
      SC_SETUP  = 6'b000010,
      SC_SCAN   = 6'b000100,
      SC_DIV    = 6'b001000,
      SC_TAKE   = 6'b010000,
      SC_FINISH = 6'b100000
   } scan_state_type;

   scan_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    t_ff, t_in;
   width_type           sw_ff, sw_in;
   width_type           tw_ff, tw_in;
   logic                gauss_ff, gauss_in;
   logic [POS_W-1:0]    centre_ff, centre_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CSR_W-1:0]    s_ff, s_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic                cut_ff, cut_in;
   logic [WEIGHT_W-1:0] raw_ff, raw_in;
   logic                bank_ff, bank_in;
   logic [1:0]          inflight_ff, inflight_in;

   logic [POS_W-1:0]    gap;
   logic                ahead;
   logic                hit;
   logic                scan_end;
   logic                go_finish;
   logic                div_start;
   logic                div_done;
   logic [DIV_Q_W-1:0]  div_quot;
   logic                accept;
   logic                take_ok;

   assign gap       = ahead ? pos_ff - centre_ff : centre_ff - pos_ff;
   assign ahead     = pos_ff >= centre_ff;
   assign hit       = gauss_ff ? (gap < POS_W'({sw_ff, 2'b00})) : (gap <= POS_W'(sw_ff));
   assign scan_end  = s_ff == sw_ff;
   assign go_finish = scan_end || (ahead && !hit);
   assign div_start = (state_ff == SC_SCAN) && !go_finish && hit && gauss_ff;
   assign req_ready = (state_ff == SC_IDLE) && (inflight_ff != 2'd2);
   assign accept    = req_valid && req_ready;
   assign take_ok   = (state_ff == SC_TAKE) && (raw_ff != '0)
                      && (count_ff != CNT_W'(MAX_TAPS));

   rtwg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .long_op (1'b0),
      .num     (DIV_NUM_W'(gap) << GAUSS_SHIFT),
      .den     (DIV_DEN_W'(sw_ff)),
      .done    (div_done),
      .quot    (div_quot)
   );

   always_comb begin
      state_in    = state_ff;
      t_in        = t_ff;
      sw_in       = sw_ff;
      tw_in       = tw_ff;
      gauss_in    = gauss_ff;
      centre_in   = centre_ff;
      pos_in      = pos_ff;
      s_in        = s_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      cut_in      = cut_ff;
      raw_in      = raw_ff;
      bank_in     = bank_ff;
      inflight_in = inflight_ff + {1'b0, accept} - {1'b0, run_done};
      case (state_ff)
         SC_IDLE: begin
            if (accept) begin
               t_in     = req_target_index;
               sw_in    = src_width;
               tw_in    = tgt_width;
               gauss_in = gauss_mode;
               state_in = SC_SETUP;
            end
         end
         SC_SETUP: begin
            centre_in = POS_W'({t_ff, 1'b1}) * POS_W'(sw_ff);
            pos_in    = POS_W'(tw_ff);
            s_in      = '0;
            count_in  = '0;
            sum_in    = '0;
            cut_in    = 1'b0;
            state_in  = (sw_ff == '0 || tw_ff == '0) ? SC_FINISH : SC_SCAN;
         end
         SC_SCAN: begin
            if (go_finish) begin
               state_in = SC_FINISH;
            end else if (hit) begin
               if (gauss_ff) begin
                  state_in = SC_DIV;
               end else begin
                  raw_in   = ONE_Q15;
                  state_in = SC_TAKE;
               end
            end else begin
               s_in   = s_ff + 1'b1;
               pos_in = pos_ff + POS_W'({tw_ff, 1'b0});
            end
         end
         SC_DIV: begin
            if (div_done) begin
               raw_in   = GAUSS_TABLE[div_quot[GAUSS_IDX_W-1:0]];
               state_in = SC_TAKE;
            end
         end
         SC_TAKE: begin
            if (raw_ff != '0 && count_ff == CNT_W'(MAX_TAPS)) begin
               cut_in   = 1'b1;
               state_in = SC_FINISH;
            end else begin
               if (take_ok) begin
                  sum_in   = sum_ff + SUM_W'(raw_ff);
                  count_in = count_ff + 1'b1;
               end
               s_in     = s_ff + 1'b1;
               pos_in   = pos_ff + POS_W'({tw_ff, 1'b0});
               state_in = SC_SCAN;
            end
         end
         SC_FINISH: begin
            if (desc_ready) begin
               bank_in  = ~bank_ff;
               state_in = SC_IDLE;
            end
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SC_IDLE;
         bank_ff     <= 1'b0;
         inflight_ff <= '0;
      end else begin
         state_ff    <= state_in;
         bank_ff     <= bank_in;
         inflight_ff <= inflight_in;
      end
      t_ff      <= t_in;
      sw_ff     <= sw_in;
      tw_ff     <= tw_in;
      gauss_ff  <= gauss_in;
      centre_ff <= centre_in;
      pos_ff    <= pos_in;
      s_ff      <= s_in;
      count_ff  <= count_in;
      sum_ff    <= sum_in;
      cut_ff    <= cut_in;
      raw_ff    <= raw_in;
   end

   assign tap_wr.en     = take_ok;
   assign tap_wr.addr   = {bank_ff, count_ff[TAP_IDX_W-1:0]};
   assign tap_wr.weight = raw_ff;
   assign tap_wr.source = s_ff[IDX_W-1:0];

   assign desc_valid  = state_ff == SC_FINISH;
   assign desc.target = t_ff;
   assign desc.count  = count_ff;
   assign desc.sum    = sum_ff;
   assign desc.cut    = cut_ff;
   assign desc.bank   = bank_ff;

endmodule

>>> rtl/rtwg_queue.sv
module rtwg_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  rtwg_pkg::run_desc_type push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output rtwg_pkg::run_desc_type pop_data
);
   import rtwg_pkg::*;

   run_desc_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = count_ff != QUEUE_CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/rtwg_norm.sv
module rtwg_norm (
   input  logic                          clock,
   input  logic                          reset,
   input  rtwg_pkg::run_desc_type        desc,
   input  logic                          desc_valid,
   output logic                          desc_ready,
   output rtwg_pkg::tap_read_type        tap_rd,
   input  logic [rtwg_pkg::WEIGHT_W-1:0] weight_rd,
   input  logic [rtwg_pkg::IDX_W-1:0]    source_rd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rtwg_pkg::IDX_W-1:0]    rsp_target_echo,
   output logic [rtwg_pkg::IDX_W-1:0]    rsp_source_index,
   output logic [rtwg_pkg::WEIGHT_W-1:0] rsp_tap_weight,
   output logic                          rsp_last_tap,
   output logic                          rsp_no_taps,
   output logic                          rsp_overflow,
   output logic                          run_done
);
   import rtwg_pkg::*;

   typedef enum logic [4:0] {
      NM_IDLE  = 5'b00001,
      NM_READ  = 5'b00010,
      NM_START = 5'b00100,
      NM_DIV   = 5'b01000,
      NM_OUT   = 5'b10000
   } norm_state_type;

   norm_state_type      state_ff, state_in;
   run_desc_type        cur_ff, cur_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [IDX_W-1:0]    echo_ff, echo_in;
   logic [IDX_W-1:0]    src_ff, src_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic                last_ff, last_in;
   logic                notaps_ff, notaps_in;
   logic                ovf_ff, ovf_in;

   logic                div_start;
   logic                div_done;
   logic [DIV_Q_W-1:0]  div_quot;
   logic [DIV_NUM_W-1:0] div_num;

   assign desc_ready = state_ff == NM_IDLE;
   assign div_start  = state_ff == NM_START;
   assign div_num    = DIV_NUM_W'({weight_rd, 15'b0}) + DIV_NUM_W'(cur_ff.sum >> 1);
   assign tap_rd.en   = state_ff == NM_READ;
   assign tap_rd.addr = {cur_ff.bank, k_ff[TAP_IDX_W-1:0]};

   rtwg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .long_op (1'b1),
      .num     (div_num),
      .den     (cur_ff.sum),
      .done    (div_done),
      .quot    (div_quot)
   );

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      k_in      = k_ff;
      echo_in   = echo_ff;
      src_in    = src_ff;
      weight_in = weight_ff;
      last_in   = last_ff;
      notaps_in = notaps_ff;
      ovf_in    = ovf_ff;
      run_done  = 1'b0;
      case (state_ff)
         NM_IDLE: begin
            if (desc_valid) begin
               cur_in  = desc;
               k_in    = '0;
               echo_in = desc.target;
               if (desc.count == '0) begin
                  src_in    = '0;
                  weight_in = '0;
                  last_in   = 1'b1;
                  notaps_in = 1'b1;
                  ovf_in    = 1'b0;
                  state_in  = NM_OUT;
               end else begin
                  state_in = NM_READ;
               end
            end
         end
         NM_READ: begin
            state_in = NM_START;
         end
         NM_START: begin
            src_in   = source_rd;
            state_in = NM_DIV;
         end
         NM_DIV: begin
            if (div_done) begin
               weight_in = (div_quot > DIV_Q_W'(ONE_Q15)) ? ONE_Q15
                                                          : div_quot[WEIGHT_W-1:0];
               last_in   = (k_ff + 1'b1) == cur_ff.count;
               notaps_in = 1'b0;
               ovf_in    = cur_ff.cut;
               state_in  = NM_OUT;
            end
         end
         NM_OUT: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  run_done = 1'b1;
                  state_in = NM_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = NM_READ;
               end
            end
         end
         default: begin
            state_in = NM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= NM_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cur_ff    <= cur_in;
      k_ff      <= k_in;
      echo_ff   <= echo_in;
      src_ff    <= src_in;
      weight_ff <= weight_in;
      last_ff   <= last_in;
      notaps_ff <= notaps_in;
      ovf_ff    <= ovf_in;
   end

   assign rsp_valid        = state_ff == NM_OUT;
   assign rsp_target_echo  = echo_ff;
   assign rsp_source_index = src_ff;
   assign rsp_tap_weight   = weight_ff;
   assign rsp_last_tap     = last_ff;
   assign rsp_no_taps      = notaps_ff;
   assign rsp_overflow     = ovf_ff;

endmodule

>>> rtl/rtwg_checker.sv
module rtwg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rtwg_pkg::IDX_W-1:0]    rsp_source_index,
   input logic [rtwg_pkg::WEIGHT_W-1:0] rsp_tap_weight,
   input logic                          rsp_last_tap,
   input logic                          rsp_no_taps,
   input logic                          rsp_overflow
);
   import rtwg_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tap_weight)
                                  && $stable(rsp_last_tap))
      else $error("transaction dropped or changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_taps |-> rsp_last_tap && !rsp_overflow
                                   && rsp_tap_weight == '0 && rsp_source_index == '0)
      else $error("empty run transaction malformed");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_tap_weight <= ONE_Q15)
      else $error("tap weight above one");

   a_tap_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_tap |=> !rsp_valid)
      else $error("next tap offered without a fetch cycle");

endmodule

bind resample_tap_weight_generator_unit rtwg_checker u_rtwg_checker (.*);
